FILE: src/pcrc_pkg.sv
package pcrc_pkg;

   localparam int unsigned BYTE_W        = 8;
   localparam int unsigned CRC_W         = 16;
   localparam int unsigned QUEUE_DEPTH   = 4;
   localparam int unsigned MODE_DATA_BIT = 7;

   localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
   localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

   localparam logic [2:0] PH_SOURCE = 3'd0;
   localparam logic [2:0] PH_ID     = 3'd1;
   localparam logic [2:0] PH_TTL    = 3'd2;
   localparam logic [2:0] PH_MODE   = 3'd3;
   localparam logic [2:0] PH_SIZE   = 3'd4;
   localparam logic [2:0] PH_DATA   = 3'd5;
   localparam logic [2:0] PH_CK_LO  = 3'd6;
   localparam logic [2:0] PH_CK_HI  = 3'd7;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              restart;
      logic              last;
      logic              check;
   } pcrc_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } pcrc_qstat_type;

   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
      for (int k = 0; k < BYTE_W; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

FILE: src/pcrc_req_if.sv
interface pcrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] packet_byte;
   logic       start_of_packet;

   modport source (output valid, output packet_byte, output start_of_packet, input ready);
   modport sink   (input valid, input packet_byte, input start_of_packet, output ready);
endinterface

FILE: src/pcrc_rsp_if.sv
interface pcrc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] crc_value;
   logic        crc_ok;

   modport source (output valid, output crc_value, output crc_ok, input ready);
   modport sink   (input valid, input crc_value, input crc_ok, output ready);
endinterface

FILE: src/packet_crc16_modbus.sv
// a result is registered: the last byte of its packet passes through the queue and then the result register
// throughput: one byte per cycle while the queue is not full, set by the combinational 8-bit crc update in the back end
// a short byte queue sits between the field parser and the crc engine
// reset (synchronous, active high) clears the parser to the source field, empties the
// queue, loads the crc with 0xffff, drops any pending result and clears check_mode
module packet_crc16_modbus
   import pcrc_pkg::*;
#(
   parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   pcrc_req_if.sink    req_port,
   pcrc_rsp_if.source  rsp_port
);

   logic           check_mode_ff;
   logic           push;
   logic           pop;
   pcrc_item_type  push_item;
   pcrc_item_type  pop_item;
   pcrc_qstat_type qstat;

   always_ff @(posedge clock) begin
      if (reset) begin
         check_mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         check_mode_ff <= csr_wr_data;
      end
   end

   pcrc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .check_mode (check_mode_ff),
      .req_port   (req_port),
      .qstat      (qstat),
      .push       (push),
      .push_item  (push_item)
   );

   pcrc_queue #(
      .DEPTH (QDEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .stat      (qstat)
   );

   pcrc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .pop_item (pop_item),
      .qstat    (qstat),
      .pop      (pop),
      .rsp_port (rsp_port)
   );

`ifndef SYNTHESIS
   a_ok_means_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && rsp_port.crc_ok |-> rsp_port.crc_value == '0)
      else $error("crc_ok set with nonzero crc");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_port.valid)
      else $error("result valid right after reset");

   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      req_port.valid && req_port.ready |=> !qstat.empty)
      else $error("transferred byte missing from queue");

   a_queue_flags: assert property (@(posedge clock) disable iff (reset)
      !(qstat.full && qstat.empty))
      else $error("queue both full and empty");
`endif

endmodule

FILE: src/pcrc_queue.sv
module pcrc_queue
   import pcrc_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  pcrc_item_type  push_item,
   input  logic           pop,
   output pcrc_item_type  pop_item,
   output pcrc_qstat_type stat
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   pcrc_item_type    entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item   = entries_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == CNT_W'(DEPTH));
   assign stat.empty = (count_ff == '0);

endmodule

FILE: src/pcrc_front.sv
module pcrc_front
   import pcrc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           check_mode,
   pcrc_req_if.sink       req_port,
   input  pcrc_qstat_type qstat,
   output logic           push,
   output pcrc_item_type  push_item
);

   logic [2:0]        phase_ff, phase_in;
   logic [BYTE_W-1:0] remaining_ff, remaining_in;
   logic              restart;
   logic              done;
   logic [2:0]        phase_cur;
   logic [BYTE_W-1:0] remaining_cur;
   logic [BYTE_W-1:0] remaining_dec;

   assign req_port.ready = !qstat.full;
   assign push           = req_port.valid && req_port.ready;

   always_comb begin
      restart       = req_port.start_of_packet || (phase_ff == PH_SOURCE);
      phase_cur     = restart ? PH_SOURCE : phase_ff;
      remaining_cur = restart ? '0 : remaining_ff;
      remaining_dec = remaining_cur - BYTE_W'(1);
      phase_in      = phase_cur;
      remaining_in  = remaining_cur;
      done          = 1'b0;
      unique case (phase_cur)
         PH_SOURCE: phase_in = PH_ID;
         PH_ID:     phase_in = PH_TTL;
         PH_TTL:    phase_in = PH_MODE;
         PH_MODE: begin
            if (req_port.packet_byte[MODE_DATA_BIT]) begin
               phase_in = PH_SIZE;
            end else if (check_mode) begin
               phase_in = PH_CK_LO;
            end else begin
               done = 1'b1;
            end
         end
         PH_SIZE: begin
            remaining_in = req_port.packet_byte;
            if (req_port.packet_byte != '0) begin
               phase_in = PH_DATA;
            end else if (check_mode) begin
               phase_in = PH_CK_LO;
            end else begin
               done = 1'b1;
            end
         end
         PH_DATA: begin
            remaining_in = remaining_dec;
            if (remaining_dec == '0) begin
               if (check_mode) begin
                  phase_in = PH_CK_LO;
               end else begin
                  done = 1'b1;
               end
            end
         end
         PH_CK_LO: phase_in = PH_CK_HI;
         PH_CK_HI: done = 1'b1;
      endcase
      if (done) begin
         phase_in     = PH_SOURCE;
         remaining_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SOURCE;
         remaining_ff <= '0;
      end else if (push) begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
      end
   end

   assign push_item.data    = req_port.packet_byte;
   assign push_item.restart = restart;
   assign push_item.last    = done;
   assign push_item.check   = check_mode;

endmodule

FILE: src/pcrc_back.sv
module pcrc_back
   import pcrc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  pcrc_item_type  pop_item,
   input  pcrc_qstat_type qstat,
   output logic           pop,
   pcrc_rsp_if.source     rsp_port
);

   logic [CRC_W-1:0] crc_ff, crc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CRC_W-1:0] rsp_crc_ff;
   logic             rsp_ok_ff;
   logic             out_free;

   assign out_free = !rsp_valid_ff || rsp_port.ready;
   assign pop      = !qstat.empty && (!pop_item.last || out_free);
   assign crc_in   = crc_byte(pop_item.restart ? CRC_INIT : crc_ff, pop_item.data);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      if (pop && pop_item.last) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= CRC_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            crc_ff <= crc_in;
         end
      end
   end

   // result register, loaded on the last byte of a packet
   always_ff @(posedge clock) begin
      if (pop && pop_item.last) begin
         rsp_crc_ff <= crc_in;
         rsp_ok_ff  <= pop_item.check && (crc_in == '0);
      end
   end

   assign rsp_port.valid     = rsp_valid_ff;
   assign rsp_port.crc_value = rsp_crc_ff;
   assign rsp_port.crc_ok    = rsp_ok_ff;

endmodule

FILE: dv/pcrc_crc_check.sv
module pcrc_crc_check
   import pcrc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic csr_wr_en,
   input  logic csr_wr_data,
   pcrc_req_if  req_mon,
   pcrc_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending_count
);

   typedef struct packed {
      logic [CRC_W-1:0] crc;
      logic             ok;
   } crc_result_type;

   crc_result_type    due_results[$];
   logic [CRC_W-1:0]  run_crc;
   logic [2:0]        field;
   logic [BYTE_W-1:0] bytes_left;
   logic              verify;
   int                errors = 0;

   // bit-serial form of the reflected crc update
   function automatic logic [CRC_W-1:0] modbus_next(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      logic             fb;
      c = crc;
      for (int i = 0; i < BYTE_W; i++) begin
         fb = c[0] ^ b[i];
         c  = {1'b0, c[CRC_W-1:1]} ^ (fb ? CRC_POLY : '0);
      end
      return c;
   endfunction

   task automatic absorb_byte(input logic [BYTE_W-1:0] b, input logic sop);
      logic payload_done;
      logic finished;
      payload_done = 1'b0;
      finished     = 1'b0;
      if (sop || field == PH_SOURCE) begin
         run_crc    = CRC_INIT;
         field      = PH_SOURCE;
         bytes_left = '0;
      end
      run_crc = modbus_next(run_crc, b);
      case (field)
         PH_SOURCE: field = PH_ID;
         PH_ID:     field = PH_TTL;
         PH_TTL:    field = PH_MODE;
         PH_MODE: begin
            if (b[MODE_DATA_BIT]) field = PH_SIZE;
            else payload_done = 1'b1;
         end
         PH_SIZE: begin
            bytes_left = b;
            if (b != '0) field = PH_DATA;
            else payload_done = 1'b1;
         end
         PH_DATA: begin
            bytes_left = bytes_left - BYTE_W'(1);
            if (bytes_left == '0) payload_done = 1'b1;
         end
         PH_CK_LO:  field = PH_CK_HI;
         default:   finished = 1'b1;
      endcase
      if (payload_done) begin
         if (verify) field = PH_CK_LO;
         else finished = 1'b1;
      end
      if (finished) begin
         due_results.push_back('{crc: run_crc, ok: verify && run_crc == '0});
         field      = PH_SOURCE;
         bytes_left = '0;
      end
   endtask

   task automatic match_result(input logic [CRC_W-1:0] crc, input logic ok);
      crc_result_type want;
      if (due_results.size() == 0) begin
         if (errors < 10) $display("unexpected rsp transfer: crc=%h ok=%b", crc, ok);
         errors++;
      end else begin
         want = due_results.pop_front();
         if (want.crc !== crc || want.ok !== ok) begin
            if (errors < 10)
               $display("rsp mismatch: expected crc=%h ok=%b, got crc=%h ok=%b",
                        want.crc, want.ok, crc, ok);
            errors++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         due_results.delete();
         run_crc    = CRC_INIT;
         field      = PH_SOURCE;
         bytes_left = '0;
         verify     = 1'b0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) match_result(rsp_mon.crc_value, rsp_mon.crc_ok);
         if (req_mon.valid && req_mon.ready)
            absorb_byte(req_mon.packet_byte, req_mon.start_of_packet);
         if (csr_wr_en) verify = csr_wr_data;
      end
      fail_count    <= errors;
      pending_count <= due_results.size();
   end

endmodule

FILE: dv/testbench.sv
module testbench;
   import pcrc_pkg::*;

   localparam int ITEM_TARGET = 1250;
   localparam int SETTLE      = QUEUE_DEPTH + 6;
   localparam int STUCK_LIMIT = 2000;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic        csr_wr_data;
   int          fail_count;
   int          pending_count;
   int          stuck_cycles = 0;
   int          items_sent = 0;
   int          burst_left = 0;
   int          pattern_age = 0;
   logic [15:0] stall_pattern = '1;
   logic        steady = 1'b0;
   logic        check_on = 1'b0;
   logic        at_boundary = 1'b1;

   pcrc_req_if req_bus();
   pcrc_rsp_if rsp_bus();

   packet_crc16_modbus dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_port    (req_bus),
      .rsp_port    (rsp_bus)
   );

   pcrc_crc_check crc_check (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #1 clock = ~clock;

   // receiver stalls follow a rotating pattern, reloaded when pattern_age counts down to zero
   always @(posedge clock) begin
      if (pattern_age == 0) begin
         pattern_age <= 31;
         case ($urandom_range(0, 3))
            0: begin
               stall_pattern <= '1;
            end
            1: begin
               stall_pattern <= 16'($urandom) | 16'h0101;
            end
            default: begin
               stall_pattern <= 16'($urandom) | 16'h8421;
            end
         endcase
      end else begin
         pattern_age   <= pattern_age - 1;
         stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
      end
      rsp_bus.ready <= stall_pattern[15];
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      do @(posedge clock); while (stuck_cycles < STUCK_LIMIT);
      $display("FAILURE");
      $finish;
   end

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
   endfunction

   task automatic push_byte(input logic [7:0] b, input logic sop);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = steady ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid           <= 1'b1;
      req_bus.packet_byte     <= b;
      req_bus.start_of_packet <= sop;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_mode(input logic v);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      check_on     = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // keep <= 0 sends the whole packet, otherwise only its first keep bytes (all of it if keep is not below its size)
   task automatic send_packet(input logic sop, input logic with_data, input int size,
                              input logic sealed, input logic good_sum, input int keep);
      logic [7:0]  pkt[$];
      logic [15:0] sum;
      pkt = {8'($urandom), 8'($urandom), 8'($urandom), {with_data, 7'($urandom)}};
      if (with_data) begin
         pkt.push_back(8'(size));
         repeat (size) pkt.push_back(8'($urandom));
      end
      if (sealed) begin
         sum = CRC_INIT;
         foreach (pkt[i]) sum = crc_step(sum, pkt[i]);
         if (!good_sum) sum ^= 16'($urandom_range(1, 65535));
         pkt.push_back(sum[7:0]);
         pkt.push_back(sum[15:8]);
      end
      if (keep > 0 && keep < pkt.size()) pkt = pkt[0:keep-1];
      foreach (pkt[i]) push_byte(pkt[i], (i == 0) ? sop : 1'b0);
   endtask

   initial begin
      int   r;
      int   size;
      int   phase_no;
      int   phase_end;
      logic sop;
      reset                   <= 1'b1;
      csr_wr_en               <= 1'b0;
      csr_wr_data             <= 1'b0;
      req_bus.valid           <= 1'b0;
      req_bus.packet_byte     <= '0;
      req_bus.start_of_packet <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // minimal packet, no data section
      push_byte(8'hFF, 1'b1);
      push_byte(8'h00, 1'b0);
      push_byte(8'h5A, 1'b0);
      push_byte(8'h00, 1'b0);
      // source without start flag while idle, zero size
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'hA5, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'h00, 1'b0);
      // start flag drops a packet in progress
      push_byte(8'h11, 1'b1);
      push_byte(8'h22, 1'b0);
      push_byte(8'h33, 1'b1);
      push_byte(8'h44, 1'b0);
      push_byte(8'h55, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h01, 1'b0);
      push_byte(8'h80, 1'b0);
      write_mode(1'b1);
      send_packet(1'b1, 1'b0, 0, 1'b1, 1'b1, -1);
      // mode switched back to generate in the middle of a packet
      push_byte(8'h01, 1'b1);
      push_byte(8'h02, 1'b0);
      push_byte(8'h03, 1'b0);
      write_mode(1'b0);
      push_byte(8'h7F, 1'b0);

      phase_no = 0;
      while (items_sent < ITEM_TARGET) begin
         write_mode(phase_no % 2 == 0);
         steady    = (phase_no % 3 == 2);
         phase_end = items_sent + 200;
         if (phase_no == 0) send_packet(1'b1, 1'b1, 255, check_on, 1'b1, -1);
         while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            size = $urandom_range(0, 99);
            if (size < 1) size = 255;
            else if (size < 4) size = $urandom_range(9, 64);
            else size = $urandom_range(0, 8);
            if (r < 78) begin
               sop = !(at_boundary && $urandom_range(0, 3) == 0);
               send_packet(sop, 1'($urandom), size, check_on, $urandom_range(0, 3) != 0, -1);
               at_boundary = 1'b1;
            end else if (r < 88) begin
               send_packet(1'b1, 1'b1, size, check_on, 1'b1, $urandom_range(1, 4));
               at_boundary = 1'b0;
            end else if (r < 95) begin
               repeat ($urandom_range(1, 6)) push_byte(8'($urandom), 1'($urandom));
               at_boundary = 1'b0;
            end else begin
               drain();
            end
         end
         phase_no++;
      end

      drain();
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: files.f
src/pcrc_pkg.sv
src/pcrc_req_if.sv
src/pcrc_rsp_if.sv
src/pcrc_queue.sv
src/pcrc_front.sv
src/pcrc_back.sv
src/packet_crc16_modbus.sv
dv/pcrc_crc_check.sv
dv/testbench.sv
